// ===== rtl/core/lsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_pkg: shared types and constants of the line segment clipper
// Register indexes, outcode bit positions and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lsc_pkg;

	// default build parameters
	localparam int COORD_WIDTH_DEF    = 16;
	localparam int MAX_CLIP_STEPS_DEF = 8;

	// configuration registers
	localparam int DIM_WIDTH       = 15;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [DIM_WIDTH-1:0] SCREEN_WIDTH_RST  = 15'd1024;
	localparam logic [DIM_WIDTH-1:0] SCREEN_HEIGHT_RST = 15'd768;

	// outcode bit positions
	localparam int CODE_BOTTOM = 0;
	localparam int CODE_TOP    = 1;
	localparam int CODE_RIGHT  = 2;
	localparam int CODE_LEFT   = 3;

	// controller to datapath
	typedef struct packed {
		logic load;       // take a new segment
		logic setup;      // pick the clip edge and latch operands
		logic mul;        // register the product
		logic div_start;  // launch the divider
		logic update;     // move the clipped end point
		logic out_load;   // capture the result beat
	} lsc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic accept;     // both outcodes clear
		logic reject;     // outcodes share a bit
		logic div_done;   // quotient ready
	} lsc_sts_t;

endpackage

// ===== rtl/core/lsc_seg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_seg_if: segment input channel
// Valid/ready channel carrying the two end points of one segment.
// ----------------------------------------------------------------------------
interface lsc_seg_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] start_x;
	logic signed [COORD_WIDTH-1:0] start_y;
	logic signed [COORD_WIDTH-1:0] end_x;
	logic signed [COORD_WIDTH-1:0] end_y;

	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== rtl/core/lsc_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_res_if: clip result channel
// Valid/ready channel carrying the visibility flag and the clipped points.
// ----------------------------------------------------------------------------
interface lsc_res_if #(
	parameter int COORD_WIDTH = 16
);
	logic                          valid;
	logic                          ready;
	logic                          visible;
	logic signed [COORD_WIDTH-1:0] clip_start_x;
	logic signed [COORD_WIDTH-1:0] clip_start_y;
	logic signed [COORD_WIDTH-1:0] clip_end_x;
	logic signed [COORD_WIDTH-1:0] clip_end_y;

	modport source (output valid, visible, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, input ready);
	modport sink   (input valid, visible, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, output ready);
endinterface

// ===== rtl/core/lsc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_div: unsigned restoring divider, two quotient bits per cycle
// Divides a 2*MW bit dividend by an MW bit divisor whose quotient is known
// to fit in MW bits.
// ----------------------------------------------------------------------------
module lsc_div import lsc_pkg::*; #(
	parameter int MW = 18
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [2*MW-1:0] dividend,
	input  logic [MW-1:0]   divisor,
	output logic            done,
	output logic [MW-1:0]   quotient
);

	localparam int ITERS = MW / 2;
	localparam int CW    = $clog2(ITERS + 1);

	logic [MW-1:0] rem_q;
	logic [MW-1:0] dvd_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	logic [MW-1:0] rem_n;
	logic [MW-1:0] dvd_n;

	// two dependent restoring steps
	always_comb begin
		logic [MW:0] trial;
		rem_n = rem_q;
		dvd_n = dvd_q;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, dvd_n[MW-1]};
			if (trial >= {1'b0, divisor}) begin
				rem_n = MW'(trial - {1'b0, divisor});
				dvd_n = {dvd_n[MW-2:0], 1'b1};
			end else begin
				rem_n = trial[MW-1:0];
				dvd_n = {dvd_n[MW-2:0], 1'b0};
			end
		end
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(ITERS);
		end else if (busy_q && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// partial remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*MW-1:MW];
			dvd_q <= dividend[MW-1:0];
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= rem_n;
			dvd_q <= dvd_n;
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = dvd_q;

endmodule

// ===== rtl/core/lsc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_dp: clipper datapath
// Holds the window size, the two working end points and their outcodes,
// the clip operand registers, the product register, the divider and the
// result registers.
// ----------------------------------------------------------------------------
module lsc_dp import lsc_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [DIM_WIDTH-1:0]          cfg_data,
	input  lsc_cmd_t                      cmd,
	output lsc_sts_t                      sts,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	output logic                          visible,
	output logic signed [COORD_WIDTH-1:0] clip_start_x,
	output logic signed [COORD_WIDTH-1:0] clip_start_y,
	output logic signed [COORD_WIDTH-1:0] clip_end_x,
	output logic signed [COORD_WIDTH-1:0] clip_end_y
);

	// working coordinates also hold window edges up to 32766
	localparam int IW = ((COORD_WIDTH > DIM_WIDTH + 1) ? COORD_WIDTH : DIM_WIDTH + 1) + 1;
	localparam int DW = IW + 1;                 // differences
	localparam int MW = ((IW + 2) / 2) * 2;     // magnitudes, even for the divider
	localparam int AW = MW + 1;                 // signed quotient term

	function automatic logic [3:0] outcode(input logic signed [IW-1:0] x,
		input logic signed [IW-1:0] y, input logic signed [IW-1:0] w,
		input logic signed [IW-1:0] h);
		logic [3:0] c;
		c = '0;
		if (y >= h)
			c[CODE_BOTTOM] = 1'b1;
		else if (y[IW-1])
			c[CODE_TOP] = 1'b1;
		if (x >= w)
			c[CODE_RIGHT] = 1'b1;
		else if (x[IW-1])
			c[CODE_LEFT] = 1'b1;
		return c;
	endfunction

	function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] v);
		logic [DW-1:0] u;
		u = v[DW-1] ? (~v + 1'b1) : v;
		return MW'(u);
	endfunction

	function automatic logic signed [DW-1:0] ext(input logic signed [IW-1:0] v);
		return {v[IW-1], v};
	endfunction

	logic [DIM_WIDTH-1:0] w_q;
	logic [DIM_WIDTH-1:0] h_q;
	logic signed [IW-1:0] w_s;
	logic signed [IW-1:0] h_s;

	logic signed [IW-1:0] x1_q, y1_q, x2_q, y2_q;
	logic [3:0]           c1, c2, sel;

	logic [MW-1:0]        mag_m_q, mag_n_q, mag_d_q;
	logic                 neg_q, dz_q, on_y_q, first_q;
	logic signed [IW-1:0] fix_q;
	logic [2*MW-1:0]      prod_q;

	logic signed [DW-1:0] dx, dy, op_m, op_n, op_d;
	logic signed [IW-1:0] op_fix;
	logic                 op_on_y;

	logic                 div_done;
	logic [MW-1:0]        quo;
	logic signed [AW-1:0] term, base, sum;
	logic signed [IW-1:0] newc;

	logic                 vis_q;
	logic signed [COORD_WIDTH-1:0] ox1_q, oy1_q, ox2_q, oy2_q;

	// window size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= SCREEN_WIDTH_RST;
			h_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  w_q <= cfg_data;
				REG_SCREEN_HEIGHT: h_q <= cfg_data;
			endcase
		end
	end

	assign w_s = $signed({{(IW-DIM_WIDTH){1'b0}}, w_q});
	assign h_s = $signed({{(IW-DIM_WIDTH){1'b0}}, h_q});

	// outcodes of the current end points
	assign c1  = outcode(x1_q, y1_q, w_s, h_s);
	assign c2  = outcode(x2_q, y2_q, w_s, h_s);
	assign sel = (c1 != '0) ? c1 : c2;

	assign sts.accept   = (c1 | c2) == '0;
	assign sts.reject   = (c1 & c2) != '0;
	assign sts.div_done = div_done;

	// clip edge selection, interpolating from the first point
	assign dx = ext(x2_q) - ext(x1_q);
	assign dy = ext(y2_q) - ext(y1_q);

	always_comb begin
		priority if (sel[CODE_BOTTOM]) begin
			op_m    = dx;
			op_n    = ext(h_s) - ext(y1_q);
			op_d    = dy;
			op_fix  = h_s - 1'b1;
			op_on_y = 1'b1;
		end else if (sel[CODE_TOP]) begin
			op_m    = dx;
			op_n    = '0 - ext(y1_q);
			op_d    = dy;
			op_fix  = '0;
			op_on_y = 1'b1;
		end else if (sel[CODE_RIGHT]) begin
			op_m    = dy;
			op_n    = ext(w_s) - ext(x1_q);
			op_d    = dx;
			op_fix  = w_s - 1'b1;
			op_on_y = 1'b0;
		end else begin
			op_m    = dy;
			op_n    = '0 - ext(x1_q);
			op_d    = dx;
			op_fix  = '0;
			op_on_y = 1'b0;
		end
	end

	// operand latch and product register
	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			mag_m_q <= mag(op_m);
			mag_n_q <= mag(op_n);
			mag_d_q <= mag(op_d);
			neg_q   <= op_m[DW-1] ^ op_n[DW-1] ^ op_d[DW-1];
			dz_q    <= (op_d == '0);
			on_y_q  <= op_on_y;
			first_q <= (c1 != '0);
			fix_q   <= op_fix;
		end
		if (cmd.mul)
			prod_q <= mag_m_q * mag_n_q;
	end

	lsc_div #(
		.MW(MW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (mag_d_q),
		.done     (div_done),
		.quotient (quo)
	);

	// new coordinate along the clip edge
	always_comb begin
		if (dz_q)
			term = '0;
		else if (neg_q)
			term = '0 - $signed({1'b0, quo});
		else
			term = $signed({1'b0, quo});
		base = on_y_q ? AW'(x1_q) : AW'(y1_q);
		sum  = base + term;
		newc = sum[IW-1:0];
	end

	// working end points
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x1_q <= {{(IW-COORD_WIDTH){start_x[COORD_WIDTH-1]}}, start_x};
			y1_q <= {{(IW-COORD_WIDTH){start_y[COORD_WIDTH-1]}}, start_y};
			x2_q <= {{(IW-COORD_WIDTH){end_x[COORD_WIDTH-1]}}, end_x};
			y2_q <= {{(IW-COORD_WIDTH){end_y[COORD_WIDTH-1]}}, end_y};
		end else if (cmd.update) begin
			if (first_q) begin
				x1_q <= on_y_q ? newc : fix_q;
				y1_q <= on_y_q ? fix_q : newc;
			end else begin
				x2_q <= on_y_q ? newc : fix_q;
				y2_q <= on_y_q ? fix_q : newc;
			end
		end
	end

	// result beat registers
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			vis_q <= sts.accept;
			ox1_q <= x1_q[COORD_WIDTH-1:0];
			oy1_q <= y1_q[COORD_WIDTH-1:0];
			ox2_q <= x2_q[COORD_WIDTH-1:0];
			oy2_q <= y2_q[COORD_WIDTH-1:0];
		end
	end

	assign visible      = vis_q;
	assign clip_start_x = ox1_q;
	assign clip_start_y = oy1_q;
	assign clip_end_x   = ox2_q;
	assign clip_end_y   = oy2_q;

endmodule

// ===== rtl/core/lsc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_ctrl: clipper sequencer
// Walks each segment through trivial accept/reject checks and edge clips,
// counts clip steps and owns the input ready and the result valid.
// ----------------------------------------------------------------------------
module lsc_ctrl import lsc_pkg::*; #(
	parameter int MAX_CLIP_STEPS = MAX_CLIP_STEPS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output lsc_cmd_t cmd,
	input  lsc_sts_t sts
);

	localparam int SW = $clog2(MAX_CLIP_STEPS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MUL,
		S_DIVLD,
		S_DIV,
		S_UPD,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [SW-1:0] step_q;
	logic          out_valid_q;
	logic          finish;
	logic          out_free;

	assign finish   = sts.accept || sts.reject || (step_q == SW'(MAX_CLIP_STEPS));
	assign out_free = !out_valid_q || out_ready;

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.setup     = (state_q == S_CHECK) && !finish;
		cmd.mul       = (state_q == S_MUL);
		cmd.div_start = (state_q == S_DIVLD);
		cmd.update    = (state_q == S_UPD);
		cmd.out_load  = (state_q == S_DONE) && out_free;
	end

	// state, step count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q  <= '0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (finish) begin
						state_q <= S_DONE;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_MUL;
					end
				end
				S_MUL:   state_q <= S_DIVLD;
				S_DIVLD: state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done)
						state_q <= S_UPD;
				end
				S_UPD:   state_q <= S_CHECK;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/line_segment_clipper.sv =====
`timescale 1ns / 1ps
// Edge clips per segment: 0 to MAX_CLIP_STEPS; the divider width MW = 18 for 16-bit points.
// Each clip runs setup, multiply, divider start, divide and update; the divider yields two
// quotient bits a cycle.
// Throughput: one segment at a time; the next segment is taken while a result waits.
// Reset: arst_n clears the sequencer and sets the window to 1024 x 768.
// ----------------------------------------------------------------------------
// line_segment_clipper: Cohen-Sutherland segment clipper
// Clips a segment to the window 0..width-1 by 0..height-1 with a sequencer
// driving a multiply/divide datapath, one edge clip at a time.
// ----------------------------------------------------------------------------
module line_segment_clipper import lsc_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int MAX_CLIP_STEPS = MAX_CLIP_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [DIM_WIDTH-1:0]       cfg_data,
	lsc_seg_if.sink                    seg,
	lsc_res_if.source                  res
);

	lsc_cmd_t cmd;
	lsc_sts_t sts;

	// sequencer
	lsc_ctrl #(
		.MAX_CLIP_STEPS(MAX_CLIP_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seg.valid),
		.in_ready  (seg.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// arithmetic and result registers
	lsc_dp #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.sts          (sts),
		.start_x      (seg.start_x),
		.start_y      (seg.start_y),
		.end_x        (seg.end_x),
		.end_y        (seg.end_y),
		.visible      (res.visible),
		.clip_start_x (res.clip_start_x),
		.clip_start_y (res.clip_start_y),
		.clip_end_x   (res.clip_end_x),
		.clip_end_y   (res.clip_end_y)
	);

endmodule

// ===== bench/lsc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsc_checker: result checker for the line segment clipper
// Watches the configuration port and both channels, predicts the clipped
// segment for every accepted input beat and compares each result beat,
// field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module lsc_checker import lsc_pkg::*; #(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int MAX_CLIP_STEPS = MAX_CLIP_STEPS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [DIM_WIDTH-1:0]       cfg_data,
	lsc_seg_if                         seg,
	lsc_res_if                         res,
	output int                         errors,
	output int                         outstanding,
	output int                         results_seen,
	output int                         results_visible
);

	typedef struct {
		logic                          visible;
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] end_x;
		logic signed [COORD_WIDTH-1:0] end_y;
	} clip_t;

	clip_t                expected_clips[$];
	logic [DIM_WIDTH-1:0] cur_width;
	logic [DIM_WIDTH-1:0] cur_height;

	// truncated (a * b) / d on a full 128-bit product, zero for a zero divisor
	function automatic longint scaled_quotient(longint num_a, longint num_b, longint den);
		logic [63:0]  mag_a;
		logic [63:0]  mag_b;
		logic [63:0]  mag_d;
		logic [127:0] quo;
		logic         negate;
		mag_a = (num_a < 0) ? -num_a : num_a;
		mag_b = (num_b < 0) ? -num_b : num_b;
		mag_d = (den < 0) ? -den : den;
		if (mag_d == 64'd0)
			return 0;
		quo = ({64'd0, mag_a} * {64'd0, mag_b}) / {64'd0, mag_d};
		negate = ((num_a < 0) != (num_b < 0)) != (den < 0);
		if (num_a == 0 || num_b == 0)
			negate = 1'b0;
		if (negate)
			return -$signed({1'b0, quo[62:0]});
		return $signed({1'b0, quo[62:0]});
	endfunction

	// outcode of one point against the window
	function automatic logic [3:0] region_code(longint x, longint y, longint w, longint h);
		logic [3:0] code;
		code = '0;
		if (y >= h)
			code[CODE_BOTTOM] = 1'b1;
		else if (y < 0)
			code[CODE_TOP] = 1'b1;
		if (x >= w)
			code[CODE_RIGHT] = 1'b1;
		else if (x < 0)
			code[CODE_LEFT] = 1'b1;
		return code;
	endfunction

	// cohen-sutherland clip of one segment
	function automatic clip_t clip_segment(logic signed [COORD_WIDTH-1:0] ax,
		logic signed [COORD_WIDTH-1:0] ay, logic signed [COORD_WIDTH-1:0] bx,
		logic signed [COORD_WIDTH-1:0] by, longint w, longint h);
		longint     x1;
		longint     y1;
		longint     x2;
		longint     y2;
		longint     nx;
		longint     ny;
		logic [3:0] c1;
		logic [3:0] c2;
		logic [3:0] sel;
		int         steps;
		clip_t      clip;
		x1 = ax;
		y1 = ay;
		x2 = bx;
		y2 = by;
		c1 = region_code(x1, y1, w, h);
		c2 = region_code(x2, y2, w, h);
		steps = 0;
		while (steps < MAX_CLIP_STEPS && (c1 | c2) != 4'd0 && (c1 & c2) == 4'd0) begin
			sel = (c1 != 4'd0) ? c1 : c2;
			// bottom and right interpolate at the size but store size-1
			if (sel[CODE_BOTTOM]) begin
				nx = x1 + scaled_quotient(x2 - x1, h - y1, y2 - y1);
				ny = h - 1;
			end else if (sel[CODE_TOP]) begin
				nx = x1 + scaled_quotient(x2 - x1, -y1, y2 - y1);
				ny = 0;
			end else if (sel[CODE_RIGHT]) begin
				nx = w - 1;
				ny = y1 + scaled_quotient(y2 - y1, w - x1, x2 - x1);
			end else begin
				nx = 0;
				ny = y1 + scaled_quotient(y2 - y1, -x1, x2 - x1);
			end
			if (c1 != 4'd0) begin
				x1 = nx;
				y1 = ny;
				c1 = region_code(x1, y1, w, h);
			end else begin
				x2 = nx;
				y2 = ny;
				c2 = region_code(x2, y2, w, h);
			end
			steps++;
		end
		clip.visible = ((c1 | c2) == 4'd0);
		clip.start_x = x1[COORD_WIDTH-1:0];
		clip.start_y = y1[COORD_WIDTH-1:0];
		clip.end_x   = x2[COORD_WIDTH-1:0];
		clip.end_y   = y2[COORD_WIDTH-1:0];
		return clip;
	endfunction

	task automatic report_mismatch(string msg);
		errors++;
		$display("result %0d: %s", results_seen, msg);
	endtask

	task automatic compare_field(string what, longint got, longint want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", what, got, want));
	endtask

	// track the window, predict on input beats, check on result beats
	always @(posedge clk or negedge arst_n) begin : watch
		clip_t want;
		if (!arst_n) begin
			cur_width <= SCREEN_WIDTH_RST;
			cur_height <= SCREEN_HEIGHT_RST;
			expected_clips.delete();
			outstanding <= 0;
			errors = 0;
			results_seen = 0;
			results_visible = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCREEN_WIDTH: cur_width <= cfg_data;
					REG_SCREEN_HEIGHT: cur_height <= cfg_data;
					default: ;
				endcase
			end
			if (seg.valid && seg.ready)
				expected_clips.push_back(clip_segment(seg.start_x, seg.start_y, seg.end_x,
					seg.end_y, longint'(cur_width), longint'(cur_height)));
			if (res.valid && res.ready) begin
				results_seen++;
				if (res.visible)
					results_visible++;
				if (expected_clips.size() == 0) begin
					report_mismatch("result beat with no segment waiting");
				end else begin
					want = expected_clips.pop_front();
					compare_field("visible", res.visible, want.visible);
					compare_field("clip_start_x", res.clip_start_x, want.start_x);
					compare_field("clip_start_y", res.clip_start_y, want.start_y);
					compare_field("clip_end_x", res.clip_end_x, want.end_x);
					compare_field("clip_end_y", res.clip_end_y, want.end_y);
				end
			end
			outstanding <= expected_clips.size();
		end
	end

endmodule

// ===== bench/tb_line_segment_clipper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_segment_clipper: testbench of the line segment clipper
// Drives hand-picked and random segments through a series of window sizes,
// zero and oversize ones among them, with random gaps on both channels.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_line_segment_clipper;
	import lsc_pkg::*;

	localparam int CW          = 16;
	localparam int CLIP_STEPS  = 8;
	localparam int WINDOWS     = 9;
	localparam int PER_WINDOW  = 112;
	localparam int CORNERS     = 20;
	localparam int LIMIT       = 800000;
	localparam int LATENCY_MAX = 3 + CLIP_STEPS * 14;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [DIM_WIDTH-1:0]       cfg_data;
	int                         cycles = 0;
	int                         segments_sent = 0;
	int                         errors;
	int                         outstanding;
	int                         results_seen;
	int                         results_visible;
	logic                       send_quiet = 1'b0;
	logic                       take_quiet = 1'b0;

	// window sizes per phase: reset values first, then extremes and odd sizes
	int win_w_set[WINDOWS] = '{1024, 1, 16384, 640, 0, 16384, 32767, 0, 13};
	int win_h_set[WINDOWS] = '{768, 1, 16384, 480, 768, 1, 32767, 0, 7};

	// hand-picked segments for the reset window of 1024 x 768
	shortint corner_cases[CORNERS][4] = '{
		'{10, 10, 500, 300},
		'{0, 0, 1023, 767},
		'{-5, -5, -100, -200},
		'{100, 100, 200, 1000},
		'{100, 100, 200, -50},
		'{100, 100, 2000, 200},
		'{100, 100, -300, 200},
		'{-100, -100, 2000, 1000},
		'{-32768, -32768, 32767, 32767},
		'{32767, -32768, -32768, 32767},
		'{32767, 32767, 32767, 32767},
		'{-32768, 0, -32768, 0},
		'{500, -1000, 500, 2000},
		'{-1000, 400, 2000, 400},
		'{1024, 768, -1, -1},
		'{-1, 767, 1024, 0},
		'{2000, 2000, 2000, 2000},
		'{21845, -21846, -21846, 21845},
		'{0, 0, 0, 0},
		'{-21846, 21845, 21845, -21846}
	};

	lsc_seg_if #(.COORD_WIDTH(CW)) seg_ch ();
	lsc_res_if #(.COORD_WIDTH(CW)) res_ch ();

	line_segment_clipper #(
		.COORD_WIDTH   (CW),
		.MAX_CLIP_STEPS(CLIP_STEPS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.seg      (seg_ch),
		.res      (res_ch)
	);

	lsc_checker #(
		.COORD_WIDTH   (CW),
		.MAX_CLIP_STEPS(CLIP_STEPS)
	) u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.seg            (seg_ch),
		.res            (res_ch),
		.errors         (errors),
		.outstanding    (outstanding),
		.results_seen   (results_seen),
		.results_visible(results_visible)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
			$display("line_segment_clipper: mismatch");
			$finish;
		end
	end

	// coordinate mostly around the window, sometimes on its edges or anywhere
	function automatic logic signed [CW-1:0] pick_coord(int size);
		int lo;
		int hi;
		int v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: begin
				lo = -(size / 2) - 4;
				hi = size + size / 2 + 4;
				v = lo + int'($urandom_range(0, hi - lo));
			end
			6, 7: begin
				case ($urandom_range(0, 2))
					0: v = 0;
					1: v = size - 1;
					default: v = size;
				endcase
				v += int'($urandom_range(0, 4)) - 2;
			end
			default: v = int'($urandom_range(0, 65535)) - 32768;
		endcase
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[CW-1:0];
	endfunction

	// one input beat after a random gap
	task automatic send_segment(logic signed [CW-1:0] x1, logic signed [CW-1:0] y1,
		logic signed [CW-1:0] x2, logic signed [CW-1:0] y2);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			seg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		seg_ch.valid <= 1'b1;
		seg_ch.start_x <= x1;
		seg_ch.start_y <= y1;
		seg_ch.end_x <= x2;
		seg_ch.end_y <= y2;
		@(posedge clk);
		while (!seg_ch.ready)
			@(posedge clk);
		segments_sent++;
	endtask

	// hold off input until every predicted result has come back
	task automatic wait_drained(int settle);
		seg_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_window(int w, int h);
		cfg_we <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= w[DIM_WIDTH-1:0];
		@(posedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_data <= h[DIM_WIDTH-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: random stall before each beat
	initial begin : result_side
		int stall;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = take_quiet ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid)
				@(posedge clk);
		end
	end

	// stimulus and verdict
	initial begin : stimulus
		int w;
		int h;
		seg_ch.valid <= 1'b0;
		seg_ch.start_x <= '0;
		seg_ch.start_y <= '0;
		seg_ch.end_x <= '0;
		seg_ch.end_y <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < WINDOWS; phase++) begin
			w = win_w_set[phase];
			h = win_h_set[phase];
			// first phase runs on the reset window
			if (phase > 0) begin
				wait_drained(4);
				write_window(w, h);
			end
			send_quiet = (phase % 3 == 1);
			take_quiet = (phase % 4 == 2);
			if (phase == 0) begin
				for (int i = 0; i < CORNERS; i++)
					send_segment(corner_cases[i][0], corner_cases[i][1],
						corner_cases[i][2], corner_cases[i][3]);
			end
			for (int i = 0; i < PER_WINDOW; i++) begin
				// a full stop halfway through each phase
				if (i == PER_WINDOW / 2)
					wait_drained(0);
				send_segment(pick_coord(w), pick_coord(h), pick_coord(w), pick_coord(h));
			end
		end

		wait_drained(LATENCY_MAX);
		$display("%0d segments clipped over %0d window sizes, zero and oversize included",
			segments_sent, WINDOWS);
		$display("%0d came back visible, %0d rejected or cut short", results_visible,
			results_seen - results_visible);
		if (errors == 0)
			$display("line_segment_clipper: match");
		else
			$display("line_segment_clipper: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/lsc_pkg.sv
rtl/core/lsc_seg_if.sv
rtl/core/lsc_res_if.sv
rtl/core/lsc_div.sv
rtl/core/lsc_dp.sv
rtl/core/lsc_ctrl.sv
rtl/core/line_segment_clipper.sv
bench/lsc_checker.sv
bench/tb_line_segment_clipper.sv
